[design/uag_pkg.sv]
// Shared types, request and configuration codes, and saturation and clamping helpers for the advection grid block.
`timescale 1ns / 1ps
package uag_pkg;
	localparam int COL_BITS  = 7;
	localparam int ROW_BITS  = 7;
	localparam int ADDR_BITS = COL_BITS + ROW_BITS;
	localparam int CELLS     = 1 << ADDR_BITS;
	localparam int VAL_BITS  = 32;
	localparam int COEF_BITS = 18;
	localparam int DIM_BITS  = 8;
	localparam int MUL_BITS  = 33;
	localparam int PROD_BITS = 2 * MUL_BITS;

	localparam logic [DIM_BITS-1:0] MIN_DIM = 8'd3;
	localparam logic [DIM_BITS-1:0] MAX_DIM = 8'd128;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_STEP = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_COEF_X = 2'd2;
	localparam logic [1:0] CFG_COEF_Y = 2'd3;

	typedef struct packed {
		logic [1:0]                 req_type;
		logic [COL_BITS-1:0]        x_index;
		logic [ROW_BITS-1:0]        y_index;
		logic signed [VAL_BITS-1:0] phi_in;
		logic signed [VAL_BITS-1:0] u_in;
		logic signed [VAL_BITS-1:0] v_in;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_BITS-1:0] phi_out;
		logic [COL_BITS-1:0]        x_out;
		logic [ROW_BITS-1:0]        y_out;
	} out_item_t;

	function automatic logic signed [VAL_BITS-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -hi - 64'sd1;
		if (v > hi) return hi[VAL_BITS-1:0];
		else if (v < lo) return lo[VAL_BITS-1:0];
		else return v[VAL_BITS-1:0];
	endfunction

	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
		if (v < MIN_DIM) return MIN_DIM;
		else if (v > MAX_DIM) return MAX_DIM;
		else return v;
	endfunction
endpackage

[design/upwind_advection_grid_step_top.sv]
// Top level of the upwind advection grid: cell memories, sequencer and border pass.
// Usage:
// An item is taken when start is high and busy is low. A load item writes phi, u
// and v of one cell. A read item returns the cell's phi in the cycle after it is
// taken: result_valid is high for one cycle with phi_out and the echoed indices;
// the receiver cannot stall, so the result is simply shown once.
// A step item walks the grid with one shared multiplier and one read port per
// memory: it copies phi into the previous grid cell by cell, updates each interior
// cell (five reads of the previous grid, four products, one write), and then
// extrapolates the border rows and columns; busy stays high until it is done.
// The configuration channel is always ready and is to be written only while the
// block is idle; the block itself does not enforce this.
// Reset sets the grid to 128 by 128 with both coefficients zero; the cell memories
// are not cleared and a cell must be loaded before it is read or stepped over.
`timescale 1ns / 1ps
module upwind_advection_grid_step_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  uag_pkg::in_item_t   req,
	output logic                result_valid,
	output uag_pkg::out_item_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import uag_pkg::*;

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001,
		ST_RD   = 17'h00002,
		ST_CPR  = 17'h00004,
		ST_CPW  = 17'h00008,
		ST_IA   = 17'h00010,
		ST_IB   = 17'h00020,
		ST_IC   = 17'h00040,
		ST_ID   = 17'h00080,
		ST_IE   = 17'h00100,
		ST_IF   = 17'h00200,
		ST_IG   = 17'h00400,
		ST_IH   = 17'h00800,
		ST_II   = 17'h01000,
		ST_IJ   = 17'h02000,
		ST_BN   = 17'h04000,
		ST_BF   = 17'h08000,
		ST_BW   = 17'h10000
	} state_t;

	state_t state_q;

	logic [DIM_BITS-1:0]  width_q, height_q;
	logic [COEF_BITS-1:0] coef_x_q, coef_y_q;
	logic [COL_BITS-1:0]  x_q, nxm1_q;
	logic [ROW_BITS-1:0]  y_q, nym1_q;
	logic                 cols_q, half_q;
	logic [COL_BITS-1:0]  rd_x_q;
	logic [ROW_BITS-1:0]  rd_y_q;

	logic signed [VAL_BITS-1:0] p_q, l_q, r_q, up_q, dn_q, u_q, v_q, near_q;
	logic signed [VAL_BITS-1:0] dx_q, dy_q, cx_q, cy_q;
	logic signed [49:0]         tx_q;

	// Cell memories.
	logic signed [VAL_BITS-1:0] cur_mem  [CELLS];
	logic signed [VAL_BITS-1:0] prev_mem [CELLS];
	logic signed [VAL_BITS-1:0] u_mem    [CELLS];
	logic signed [VAL_BITS-1:0] v_mem    [CELLS];
	logic signed [VAL_BITS-1:0] cur_rd, prev_rd, u_rd, v_rd;

	logic                       accept;
	logic                       cur_we, uv_we, prev_we;
	logic [ADDR_BITS-1:0]       cur_waddr, cur_raddr, prev_raddr, cell_addr;
	logic signed [VAL_BITS-1:0] cur_wdata;

	logic [COL_BITS-1:0] bn_x, bf_x, bt_x;
	logic [ROW_BITS-1:0] bn_y, bf_y, bt_y;

	logic signed [MUL_BITS-1:0]  mul_a, mul_b;
	logic signed [PROD_BITS-1:0] mul_q;
	logic signed [PROD_BITS-1:0] mul_sh;
	logic signed [63:0]          new_phi, ext_val;
	logic [DIM_BITS-1:0]         nx_c, ny_c;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cell_addr = {y_q, x_q};
	assign nx_c      = clamp_dim(width_q);
	assign ny_c      = clamp_dim(height_q);
	assign mul_sh    = mul_q >>> 16;

	// Border geometry: rows first (last row then row zero), then columns (column zero then last column).
	always_comb begin
		if (!cols_q) begin
			bn_x = x_q;
			bf_x = x_q;
			bt_x = x_q;
			bn_y = half_q ? ROW_BITS'(1) : nym1_q - ROW_BITS'(1);
			bf_y = half_q ? ROW_BITS'(2) : nym1_q - ROW_BITS'(2);
			bt_y = half_q ? ROW_BITS'(0) : nym1_q;
		end else begin
			bn_y = y_q;
			bf_y = y_q;
			bt_y = y_q;
			bn_x = half_q ? nxm1_q - COL_BITS'(1) : COL_BITS'(1);
			bf_x = half_q ? nxm1_q - COL_BITS'(2) : COL_BITS'(2);
			bt_x = half_q ? nxm1_q : COL_BITS'(0);
		end
	end

	always_comb begin
		case (state_q)
			ST_CPR:  cur_raddr = cell_addr;
			ST_BN:   cur_raddr = {bn_y, bn_x};
			ST_BF:   cur_raddr = {bf_y, bf_x};
			default: cur_raddr = {req.y_index, req.x_index};
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IB:   prev_raddr = {y_q, x_q - COL_BITS'(1)};
			ST_IC:   prev_raddr = {y_q, x_q + COL_BITS'(1)};
			ST_ID:   prev_raddr = {y_q - ROW_BITS'(1), x_q};
			ST_IE:   prev_raddr = {y_q + ROW_BITS'(1), x_q};
			default: prev_raddr = cell_addr;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IF:   begin mul_a = MUL_BITS'(u_q);  mul_b = MUL_BITS'({1'b0, coef_x_q}); end
			ST_IG:   begin mul_a = MUL_BITS'(v_q);  mul_b = MUL_BITS'({1'b0, coef_y_q}); end
			ST_IH:   begin mul_a = MUL_BITS'(cx_q); mul_b = MUL_BITS'(dx_q); end
			default: begin mul_a = MUL_BITS'(cy_q); mul_b = MUL_BITS'(dy_q); end
		endcase
	end

	uag_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_q)
	);

	assign new_phi = 64'(p_q) - 64'(tx_q) - 64'(mul_sh);
	assign ext_val = 64'(near_q) + 64'(near_q) - 64'(cur_rd);

	always_comb begin
		cur_we    = 1'b0;
		cur_waddr = {req.y_index, req.x_index};
		cur_wdata = req.phi_in;
		case (state_q)
			ST_IDLE: cur_we = accept && (req.req_type == REQ_LOAD);
			ST_IJ: begin
				cur_we    = 1'b1;
				cur_waddr = cell_addr;
				cur_wdata = sat32(new_phi);
			end
			ST_BW: begin
				cur_we    = 1'b1;
				cur_waddr = {bt_y, bt_x};
				cur_wdata = sat32(ext_val);
			end
			default: cur_we = 1'b0;
		endcase
	end

	assign uv_we   = accept && (req.req_type == REQ_LOAD);
	assign prev_we = (state_q == ST_CPW);

	always_ff @(posedge clk) begin
		if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
		cur_rd <= cur_mem[cur_raddr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[cell_addr] <= cur_rd;
		prev_rd <= prev_mem[prev_raddr];
	end

	always_ff @(posedge clk) begin
		if (uv_we) begin
			u_mem[{req.y_index, req.x_index}] <= req.u_in;
			v_mem[{req.y_index, req.x_index}] <= req.v_in;
		end
		u_rd <= u_mem[cell_addr];
		v_rd <= v_mem[cell_addr];
	end

	// Datapath registers of the interior update and the border pass.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IB: begin
				p_q <= prev_rd;
				u_q <= u_rd;
				v_q <= v_rd;
			end
			ST_IC: l_q <= prev_rd;
			ST_ID: r_q <= prev_rd;
			ST_IE: begin
				up_q <= prev_rd;
				dx_q <= u_q[VAL_BITS-1] ? sat32(64'(r_q) - 64'(p_q))
				                        : sat32(64'(p_q) - 64'(l_q));
			end
			ST_IF: dn_q <= prev_rd;
			ST_IG: begin
				cx_q <= sat32(64'(mul_sh));
				dy_q <= v_q[VAL_BITS-1] ? sat32(64'(dn_q) - 64'(p_q))
				                        : sat32(64'(p_q) - 64'(up_q));
			end
			ST_IH: cy_q <= sat32(64'(mul_sh));
			ST_II: tx_q <= mul_sh[49:0];
			ST_BF: near_q <= cur_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_DIM;
			height_q <= MAX_DIM;
			coef_x_q <= '0;
			coef_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[DIM_BITS-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_BITS-1:0];
				CFG_COEF_X: coef_x_q <= cfg_data[COEF_BITS-1:0];
				CFG_COEF_Y: coef_y_q <= cfg_data[COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			nxm1_q  <= '0;
			nym1_q  <= '0;
			cols_q  <= 1'b0;
			half_q  <= 1'b0;
			rd_x_q  <= '0;
			rd_y_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_STEP: begin
								nxm1_q  <= COL_BITS'(nx_c - DIM_BITS'(1));
								nym1_q  <= ROW_BITS'(ny_c - DIM_BITS'(1));
								x_q     <= '0;
								y_q     <= '0;
								state_q <= ST_CPR;
							end
							REQ_READ: begin
								rd_x_q  <= req.x_index;
								rd_y_q  <= req.y_index;
								state_q <= ST_RD;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RD:  state_q <= ST_IDLE;
				ST_CPR: state_q <= ST_CPW;
				ST_CPW: begin
					if (x_q != nxm1_q) begin
						x_q     <= x_q + COL_BITS'(1);
						state_q <= ST_CPR;
					end else if (y_q != nym1_q) begin
						x_q     <= '0;
						y_q     <= y_q + ROW_BITS'(1);
						state_q <= ST_CPR;
					end else begin
						x_q     <= COL_BITS'(1);
						y_q     <= ROW_BITS'(1);
						state_q <= ST_IA;
					end
				end
				ST_IA: state_q <= ST_IB;
				ST_IB: state_q <= ST_IC;
				ST_IC: state_q <= ST_ID;
				ST_ID: state_q <= ST_IE;
				ST_IE: state_q <= ST_IF;
				ST_IF: state_q <= ST_IG;
				ST_IG: state_q <= ST_IH;
				ST_IH: state_q <= ST_II;
				ST_II: state_q <= ST_IJ;
				ST_IJ: begin
					if (y_q != nym1_q - ROW_BITS'(1)) begin
						y_q     <= y_q + ROW_BITS'(1);
						state_q <= ST_IA;
					end else if (x_q != nxm1_q - COL_BITS'(1)) begin
						y_q     <= ROW_BITS'(1);
						x_q     <= x_q + COL_BITS'(1);
						state_q <= ST_IA;
					end else begin
						x_q     <= '0;
						y_q     <= '0;
						cols_q  <= 1'b0;
						half_q  <= 1'b0;
						state_q <= ST_BN;
					end
				end
				ST_BN: state_q <= ST_BF;
				ST_BF: state_q <= ST_BW;
				ST_BW: begin
					state_q <= ST_BN;
					if (!half_q) begin
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						if (!cols_q) begin
							if (x_q != nxm1_q) begin
								x_q <= x_q + COL_BITS'(1);
							end else begin
								cols_q <= 1'b1;
								y_q    <= '0;
							end
						end else if (y_q != nym1_q) begin
							y_q <= y_q + ROW_BITS'(1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid   = (state_q == ST_RD);
	assign result.phi_out = cur_rd;
	assign result.x_out   = rd_x_q;
	assign result.y_out   = rd_y_q;

	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("read result held for more than one cycle");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == REQ_READ) |=> result_valid)
		else $error("read item did not produce a result");

	a_read_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == REQ_READ) |=>
			(result.x_out == $past(req.x_index) && result.y_out == $past(req.y_index)))
		else $error("read result indices do not match the request");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type != REQ_READ) |=> !result_valid)
		else $error("result without a read item");
endmodule

[design/uag_mul.sv]
// Shared signed multiplier with a registered product, used for every step product.
`timescale 1ns / 1ps
module uag_mul (
	input  logic                                  clk,
	input  logic signed [uag_pkg::MUL_BITS-1:0]   a,
	input  logic signed [uag_pkg::MUL_BITS-1:0]   b,
	output logic signed [uag_pkg::PROD_BITS-1:0]  p_q
);
	import uag_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

[dv/tb_upwind_advection_grid_step_top.sv]
// Self-checking testbench for the upwind advection grid step block.
`timescale 1ns / 1ps
module tb_upwind_advection_grid_step_top;
	import uag_pkg::*;

	localparam int GRID_MAX = 128;
	localparam int CYCLE_LIMIT = 6000000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t req = '0;
	logic result_valid;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_WIDTH;
	logic [31:0] cfg_data = '0;

	upwind_advection_grid_step_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predicted state of the block.
	longint phi_now [CELLS];
	longint phi_old [CELLS];
	int vel_u [CELLS];
	int vel_v [CELLS];
	logic [7:0] width_reg = 8'd128;
	logic [7:0] height_reg = 8'd128;
	logic [17:0] kx_reg = '0;
	logic [17:0] ky_reg = '0;

	in_item_t pending_items[$];
	out_item_t awaited_cells[$];
	bit loaded [CELLS];
	int loaded_list[$];
	bit no_gaps = 1'b0;
	int errors = 0;
	int n_loads = 0, n_steps = 0, n_reads = 0, n_checked = 0;
	int random_items = 0;
	longint cycles = 0;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic int dim_used(logic [7:0] v);
		if (v < 3) return 3;
		return (v > GRID_MAX) ? GRID_MAX : int'(v);
	endfunction

	function automatic longint upwind_term(int s, longint k, longint here, longint back,
		longint fwd);
		longint c;
		longint d;
		c = clip32((longint'(s) * k) >>> 16);
		d = clip32((s < 0) ? fwd - here : here - back);
		return (c * d) >>> 16;
	endfunction

	function automatic longint extrap(longint near_v, longint far_v);
		return clip32(2 * near_v - far_v);
	endfunction

	task automatic advance_grid();
		int nx;
		int ny;
		int a;
		longint p;
		longint tx;
		longint ty;
		nx = dim_used(width_reg);
		ny = dim_used(height_reg);
		for (int y = 0; y < ny; y++)
			for (int x = 0; x < nx; x++)
				phi_old[y*GRID_MAX+x] = phi_now[y*GRID_MAX+x];
		for (int x = 1; x + 1 < nx; x++)
			for (int y = 1; y + 1 < ny; y++) begin
				a = y*GRID_MAX + x;
				p = phi_old[a];
				tx = upwind_term(vel_u[a], longint'(kx_reg), p, phi_old[a-1], phi_old[a+1]);
				ty = upwind_term(vel_v[a], longint'(ky_reg), p, phi_old[a-GRID_MAX],
					phi_old[a+GRID_MAX]);
				phi_now[a] = clip32(p - tx - ty);
			end
		for (int x = 0; x < nx; x++) begin
			phi_now[(ny-1)*GRID_MAX+x] = extrap(phi_now[(ny-2)*GRID_MAX+x],
				phi_now[(ny-3)*GRID_MAX+x]);
			phi_now[x] = extrap(phi_now[GRID_MAX+x], phi_now[2*GRID_MAX+x]);
		end
		for (int y = 0; y < ny; y++) begin
			a = y*GRID_MAX;
			phi_now[a] = extrap(phi_now[a+1], phi_now[a+2]);
			phi_now[a+nx-1] = extrap(phi_now[a+nx-2], phi_now[a+nx-3]);
		end
	endtask

	task automatic apply_item(in_item_t it);
		int a;
		out_item_t o;
		a = int'(it.y_index)*GRID_MAX + int'(it.x_index);
		case (it.req_type)
			REQ_LOAD: begin
				phi_now[a] = longint'(it.phi_in);
				vel_u[a] = it.u_in;
				vel_v[a] = it.v_in;
				n_loads++;
			end
			REQ_STEP: begin
				advance_grid();
				n_steps++;
			end
			REQ_READ: begin
				o.phi_out = phi_now[a][31:0];
				o.x_out = it.x_index;
				o.y_out = it.y_index;
				awaited_cells.push_back(o);
				n_reads++;
			end
			default: ;
		endcase
	endtask

	// Driver: one item per accepted handshake, random gaps between items unless no_gaps is set.
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap = 0;
		end else begin
			if (start && !busy) apply_item(req);
			if (!(start && busy)) begin
				if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req <= pending_items.pop_front();
					start <= 1'b1;
					if (no_gaps) gap = 0;
					else if ($urandom_range(0, 99) < 60) gap = 0;
					else if ($urandom_range(0, 99) < 90) gap = $urandom_range(1, 3);
					else gap = $urandom_range(10, 60);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result must match the oldest awaited read.
	always @(posedge clk) begin
		out_item_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (arst_n && result_valid) begin
			if (awaited_cells.size() == 0) begin
				$error("result with no read outstanding: x %0d y %0d",
					result.x_out, result.y_out);
				errors++;
			end else begin
				e = awaited_cells.pop_front();
				n_checked++;
				if (result.phi_out !== e.phi_out) begin
					$error("phi_out expected %0d actual %0d", e.phi_out, result.phi_out);
					errors++;
				end
				if (result.x_out !== e.x_out) begin
					$error("x_out expected %0d actual %0d", e.x_out, result.x_out);
					errors++;
				end
				if (result.y_out !== e.y_out) begin
					$error("y_out expected %0d actual %0d", e.y_out, result.y_out);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r < 60) return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
		return $urandom;
	endfunction

	function automatic in_item_t make_item(logic [1:0] kind, int x, int y);
		in_item_t it;
		it.req_type = kind;
		it.x_index = x[6:0];
		it.y_index = y[6:0];
		it.phi_in = pick_value();
		it.u_in = pick_value();
		it.v_in = pick_value();
		return it;
	endfunction

	task automatic queue_load(int x, int y);
		int a;
		a = y*GRID_MAX + x;
		pending_items.push_back(make_item(REQ_LOAD, x, y));
		if (!loaded[a]) begin
			loaded[a] = 1'b1;
			loaded_list.push_back(a);
		end
	endtask

	task automatic queue_read(int a);
		pending_items.push_back(make_item(REQ_READ, a % GRID_MAX, a / GRID_MAX));
	endtask

	task automatic fill_grid();
		for (int y = 0; y < dim_used(height_reg); y++)
			for (int x = 0; x < dim_used(width_reg); x++)
				if (!loaded[y*GRID_MAX+x]) queue_load(x, y);
	endtask

	// Waits until the sender has nothing left and every read has returned.
	task automatic drain();
		do @(posedge clk);
		while (pending_items.size() != 0 || start || awaited_cells.size() != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WIDTH: width_reg = val[7:0];
			CFG_HEIGHT: height_reg = val[7:0];
			CFG_COEF_X: kx_reg = val[17:0];
			default: ky_reg = val[17:0];
		endcase
	endtask

	task automatic set_all(int w, int h, int kx, int ky);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_COEF_X, kx);
		write_reg(CFG_COEF_Y, ky);
		@(posedge clk);
	endtask

	function automatic int pick_coef();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 262143;
			2: return 65536;
			default: return $urandom_range(0, 262143);
		endcase
	endfunction

	initial begin
		int w, h, r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: smallest grid with extreme values, both coefficients at full scale.
		set_all(3, 3, 262143, 262143);
		for (int y = 0; y < 3; y++)
			for (int x = 0; x < 3; x++) begin
				queue_load(x, y);
				pending_items[$].phi_in = ((x + y) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
				pending_items[$].u_in = (x == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				pending_items[$].v_in = (y == 1) ? 32'hFFFF_0000 : 32'h0;
			end
		queue_load(127, 127);
		pending_items.push_back(make_item(REQ_UNUSED, 5, 5));
		pending_items.push_back(make_item(REQ_STEP, 0, 0));
		for (int a = 0; a < 3; a++) queue_read(a * GRID_MAX + a);
		queue_read(127 * GRID_MAX + 127);
		queue_read(2 * GRID_MAX);
		pending_items.push_back(make_item(REQ_STEP, 0, 0));
		queue_read(GRID_MAX + 1);
		drain();

		// Sizes below three clamp up to three.
		set_all(0, 2, 0, 262143);
		pending_items.push_back(make_item(REQ_STEP, 0, 0));
		for (int a = 0; a < 3; a++) queue_read(2 * GRID_MAX + a);
		drain();

		// Full width, a width above the store clamped down.
		set_all(255, 3, pick_coef(), pick_coef());
		no_gaps = 1'b1;
		fill_grid();
		pending_items.push_back(make_item(REQ_STEP, 0, 0));
		no_gaps = 1'b0;
		for (int i = 0; i < 20; i++)
			queue_read(loaded_list[$urandom_range(0, loaded_list.size()-1)]);
		queue_read(0);
		queue_read(GRID_MAX * GRID_MAX - 1);
		drain();

		// Random phases on mostly small grids.
		while (random_items < 1500) begin
			r = $urandom_range(0, 99);
			w = (r < 10) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			h = (r >= 90) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			if (r >= 95) begin
				h = $urandom_range(0, 1) ? 128 : 200;
				w = $urandom_range(0, 3);
			end
			set_all(w, h, pick_coef(), pick_coef());
			no_gaps = ($urandom_range(0, 3) == 0);
			fill_grid();
			for (int i = 0; i < 150; i++) begin
				r = $urandom_range(0, 99);
				if (r < 8) pending_items.push_back(make_item(REQ_STEP, 0, 0));
				else if (r < 45) queue_read(loaded_list[$urandom_range(0, loaded_list.size()-1)]);
				else if (r < 75) queue_load($urandom_range(0, dim_used(width_reg)-1),
					$urandom_range(0, dim_used(height_reg)-1));
				else if (r < 95) queue_load($urandom_range(0, 127), $urandom_range(0, 127));
				else begin
					pending_items.push_back(make_item(REQ_UNUSED, $urandom_range(0, 127),
						$urandom_range(0, 127)));
					random_items--;
				end
				random_items++;
			end
			drain();
		end

		$display("Covered %0d loads, %0d steps and %0d reads; %0d results compared.",
			n_loads, n_steps, n_reads, n_checked);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
